// ----- design/bdf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bdf_pkg;

  // fixed field widths
  localparam int IN_VALUE_W = 32;
  localparam int CFG_W      = 4;
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 4;

  // parameter defaults
  localparam int NUM_DIGITS_DEF = 10;
  localparam int VALUE_BITS_DEF = 32;

  // register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_DIGIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECIMAL_DIGITS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DOT_ENABLE     = 2'd3;

  // register reset values
  localparam logic [CFG_W-1:0] DIGIT_COUNT_RST    = 4'd10;
  localparam logic [CFG_W-1:0] FIRST_DIGIT_RST    = 4'd0;
  localparam logic [CFG_W-1:0] DECIMAL_DIGITS_RST = 4'd0;
  localparam logic             DOT_ENABLE_RST     = 1'b0;

  // digit arithmetic and characters
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 4'd10;
  localparam logic [DIGIT_W-1:0] DIGIT_HALF = 4'd5;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0]  CHAR_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0]  CHAR_A     = 8'h41;

  typedef struct packed {
    logic load;        // capture input word, clear digits
    logic shift;       // one conversion step
    logic emit_digit;  // load digit char into output register
    logic emit_dot;    // load '.' into output register
    logic last;        // last flag for the char being loaded
    logic advance;     // step to next window position
  } cmd_t;

  typedef struct packed {
    logic conv_last;   // final conversion step this cycle
    logic win_empty;   // window has zero length
    logic at_dot;      // dot follows current position
    logic at_end;      // current position is the last digit
    logic out_free;    // output register can take a char
  } stat_t;

  function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] d8;
    d8 = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < DIGIT_TEN) begin
      return CHAR_ZERO + d8;
    end else begin
      return CHAR_A + d8 - {{(CHAR_W-DIGIT_W){1'b0}}, DIGIT_TEN};
    end
  endfunction

endpackage

`default_nettype wire

// ----- design/bdf_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bdf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire bdf_pkg::stat_t st,
  output bdf_pkg::cmd_t      cmd
);
  import bdf_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CONV  = 2'd1;
  localparam logic [1:0] S_DIGIT = 2'd2;
  localparam logic [1:0] S_DOT   = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        cmd.shift = 1'b1;
        if (st.conv_last) begin
          state_nxt = st.win_empty ? S_IDLE : S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (st.out_free) begin
          cmd.emit_digit = 1'b1;
          cmd.last       = st.at_end && !st.at_dot;
          if (st.at_dot) begin
            state_nxt = S_DOT;
          end else if (st.at_end) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      S_DOT: begin
        if (st.out_free) begin
          cmd.emit_dot = 1'b1;
          cmd.last     = st.at_end;
          if (st.at_end) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = S_DIGIT;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_load_to_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_CONV))
    else $error("accepted word did not start conversion");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_digit || cmd.emit_dot) |-> st.out_free)
    else $error("char loaded into busy output register");

  a_emit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.emit_digit && cmd.emit_dot))
    else $error("digit and dot loaded together");

endmodule

`default_nettype wire

// ----- design/bdf_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bdf_datapath #(
  parameter int NUM_DIGITS = bdf_pkg::NUM_DIGITS_DEF,
  parameter int VALUE_BITS = bdf_pkg::VALUE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [bdf_pkg::IN_VALUE_W-1:0]    in_value,
  input  wire logic                              cfg_we,
  input  wire logic [bdf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bdf_pkg::CFG_W-1:0]         cfg_data,
  input  wire bdf_pkg::cmd_t                     cmd,
  output bdf_pkg::stat_t                         st,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [bdf_pkg::CHAR_W-1:0]             out_char_out,
  output logic                                   out_last
);
  import bdf_pkg::*;

  localparam int WW = $clog2(NUM_DIGITS + 16);
  localparam int PW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int BW = $clog2(VALUE_BITS);

  logic [CFG_W-1:0] digit_count_r, first_digit_r, decimal_digits_r;
  logic             dot_enable_r;

  logic [VALUE_BITS-1:0]            shift_r;
  logic [BW-1:0]                    bit_cnt_r;
  logic [DIGIT_W-1:0]               dig_r    [NUM_DIGITS];
  logic [DIGIT_W-1:0]               dig_nxt  [NUM_DIGITS];
  logic [WW-1:0]                    k_r;
  logic                             out_valid_r;
  logic [CHAR_W-1:0]                out_char_r;
  logic                             out_last_r;

  logic [VALUE_BITS+IN_VALUE_W-1:0] value_ext;
  logic [NUM_DIGITS-1:0]            carry;
  logic [DIGIT_W-1:0]               dbl;
  logic [WW-1:0] fd_w, start_w, room_w, dc_w, len_w, dd_w, dot_at_w, pos_w;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_count_r    <= DIGIT_COUNT_RST;
      first_digit_r    <= FIRST_DIGIT_RST;
      decimal_digits_r <= DECIMAL_DIGITS_RST;
      dot_enable_r     <= DOT_ENABLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIGIT_COUNT:    digit_count_r    <= cfg_data;
        REG_FIRST_DIGIT:    first_digit_r    <= cfg_data;
        REG_DECIMAL_DIGITS: decimal_digits_r <= cfg_data;
        REG_DOT_ENABLE:     dot_enable_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // window geometry
  always_comb begin
    fd_w     = WW'(first_digit_r);
    start_w  = (fd_w >= WW'(NUM_DIGITS)) ? WW'(NUM_DIGITS - 1) : fd_w;
    room_w   = WW'(NUM_DIGITS) - start_w;
    dc_w     = WW'(digit_count_r);
    len_w    = (dc_w > room_w) ? room_w : dc_w;
    dd_w     = WW'(decimal_digits_r);
    dot_at_w = (dot_enable_r && (dd_w < len_w)) ? (len_w - dd_w) : '0;
    pos_w    = start_w + len_w - k_r;
  end

  // one double-dabble step; a digit >= 5 carries into the next digit after doubling
  always_comb begin
    carry[0] = shift_r[VALUE_BITS-1];
    for (int i = 1; i < NUM_DIGITS; i++) begin
      carry[i] = (dig_r[i-1] >= DIGIT_HALF);
    end
    for (int i = 0; i < NUM_DIGITS; i++) begin
      dbl = {dig_r[i][DIGIT_W-2:0], carry[i]};
      // top digit is never reduced, wraps in its nibble
      if ((i < NUM_DIGITS - 1) && (dig_r[i] >= DIGIT_HALF)) begin
        dig_nxt[i] = dbl - DIGIT_TEN;
      end else begin
        dig_nxt[i] = dbl;
      end
    end
  end

  assign value_ext = {{VALUE_BITS{1'b0}}, in_value};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      shift_r   <= value_ext[VALUE_BITS-1:0];
      bit_cnt_r <= BW'(VALUE_BITS - 1);
      k_r       <= WW'(1);
      for (int i = 0; i < NUM_DIGITS; i++) begin
        dig_r[i] <= '0;
      end
    end else begin
      if (cmd.shift) begin
        shift_r   <= {shift_r[VALUE_BITS-2:0], 1'b0};
        bit_cnt_r <= bit_cnt_r - BW'(1);
        for (int i = 0; i < NUM_DIGITS; i++) begin
          dig_r[i] <= dig_nxt[i];
        end
      end
      if (cmd.advance) begin
        k_r <= k_r + WW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_digit || cmd.emit_dot) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_digit) begin
      out_char_r <= to_ascii(dig_r[pos_w[PW-1:0]]);
      out_last_r <= cmd.last;
    end else if (cmd.emit_dot) begin
      out_char_r <= CHAR_DOT;
      out_last_r <= cmd.last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_char_out = out_char_r;
  assign out_last     = out_last_r;

  always_comb begin
    st.conv_last = (bit_cnt_r == '0);
    st.win_empty = (len_w == '0);
    st.at_dot    = (k_r == dot_at_w);
    st.at_end    = (k_r == len_w);
    st.out_free  = !out_valid_r || !out_stall;
  end

  a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_digit |-> ((k_r != '0) && (k_r <= len_w)))
    else $error("digit position outside window");

endmodule

`default_nettype wire

// ----- design/binary_to_decimal_ascii_formatter_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Port group  Direction  Signals                        Notes
// in_         input      in_valid, in_stall, in_value   one binary word per value
// out_         output     out_valid, out_stall,          ASCII chars of each word,
//                        out_char_out, out_last         out_last on final char
// cfg_        input      cfg_we, cfg_index, cfg_data    write only, no wait
//
// A word is accepted in S_IDLE, converted in S_CONV by one double-dabble step
// per input bit, then emitted from S_DIGIT and S_DOT one char per cycle while
// the output register is free; output stalls hold the emission.
// The output register lets the next word be accepted while the last char waits.
// Reset is synchronous: config returns to defaults, no storage needs clearing.

module binary_to_decimal_ascii_formatter_top #(
  parameter int NUM_DIGITS = bdf_pkg::NUM_DIGITS_DEF,
  parameter int VALUE_BITS = bdf_pkg::VALUE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [bdf_pkg::IN_VALUE_W-1:0] in_value,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [bdf_pkg::CHAR_W-1:0]          out_char_out,
  output logic                                out_last,
  input  wire logic                           cfg_we,
  input  wire logic [bdf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bdf_pkg::CFG_W-1:0]      cfg_data
);
  import bdf_pkg::*;

  cmd_t  cmd;
  stat_t st;

  bdf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  bdf_datapath #(
    .NUM_DIGITS (NUM_DIGITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_value     (in_value),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .st           (st),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char_out (out_char_out),
    .out_last     (out_last)
  );

endmodule

`default_nettype wire

// ----- dv/binary_to_decimal_ascii_formatter_top_tb.sv -----
`timescale 1ns / 1ps

module binary_to_decimal_ascii_formatter_top_tb;
  import bdf_pkg::*;

  localparam int N_DIGITS        = NUM_DIGITS_DEF;
  localparam int SETTLE_CYCLES   = 80;
  localparam int LONG_HOLD       = 400;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int PHASES          = 6;
  localparam int WORDS_PER_PHASE = 16;
  localparam int N_DIRECTED      = 22;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  typedef struct packed {
    logic [CFG_W-1:0]      count;
    logic [CFG_W-1:0]      first;
    logic [CFG_W-1:0]      decimals;
    logic [CFG_W-1:0]      dot_data;
    logic [IN_VALUE_W-1:0] value;
  } fmt_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [IN_VALUE_W-1:0] in_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CHAR_W-1:0]     out_char_out;
  logic                  out_last;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_DIGIT_COUNT;
  logic [CFG_W-1:0]      cfg_data = '0;

  // format registers as the block should hold them
  logic [CFG_W-1:0]   fmt_count    = DIGIT_COUNT_RST;
  logic [CFG_W-1:0]   fmt_first    = FIRST_DIGIT_RST;
  logic [CFG_W-1:0]   fmt_decimals = DECIMAL_DIGITS_RST;
  logic               fmt_dot      = DOT_ENABLE_RST;
  logic [4*CFG_W-1:0] cfg_written  = {DIGIT_COUNT_RST, FIRST_DIGIT_RST, DECIMAL_DIGITS_RST,
                                      {(CFG_W-1){1'b0}}, DOT_ENABLE_RST};

  text_char_t expected_text [$];
  text_char_t want;
  int         mismatches = 0;
  int         idle_cycles = 0;

  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;
  int stall_left = 0;
  int free_left = 0;

  // '?' means the row is checked against the predictor
  fmt_row_t directed_rows [N_DIRECTED] = '{
    '{4'd10, 4'd0,  4'd0,  4'h0, 32'd0},
    '{4'd10, 4'd0,  4'd0,  4'h0, 32'hFFFF_FFFF},
    '{4'd10, 4'd0,  4'd0,  4'h0, 32'd1234567890},
    '{4'd10, 4'd0,  4'd0,  4'h0, 32'h8000_0000},
    '{4'd10, 4'd0,  4'd0,  4'h1, 32'hFFFF_FFFF},
    '{4'd10, 4'd0,  4'd2,  4'h1, 32'd123456789},
    '{4'd10, 4'd0,  4'd10, 4'h1, 32'hFFFF_FFFF},
    '{4'd10, 4'd0,  4'd15, 4'h1, 32'd4000000000},
    '{4'd4,  4'd0,  4'd0,  4'hE, 32'hFFFF_FFFF},
    '{4'd3,  4'd2,  4'd0,  4'h0, 32'hFFFF_FFFF},
    '{4'd15, 4'd5,  4'd0,  4'h0, 32'hFFFF_FFFF},
    '{4'd3,  4'd12, 4'd0,  4'h0, 32'hFFFF_FFFF},
    '{4'd15, 4'd15, 4'd0,  4'hF, 32'hFFFF_FFFF},
    '{4'd15, 4'd6,  4'd1,  4'h1, 32'hFFFF_FFFF},
    '{4'd0,  4'd0,  4'd0,  4'h0, 32'd123},
    '{4'd0,  4'd0,  4'd0,  4'h1, 32'hFFFF_FFFF},
    '{4'd1,  4'd0,  4'd0,  4'h1, 32'd9},
    '{4'd1,  4'd0,  4'd1,  4'h1, 32'd9},
    '{4'd10, 4'd9,  4'd0,  4'h0, 32'd4000000000},
    '{4'd10, 4'd0,  4'd9,  4'h1, 32'h5A5A_5A5A},
    '{4'd10, 4'd0,  4'd5,  4'h1, 32'hA5A5_A5A5},
    '{4'd10, 4'd0,  4'd0,  4'h0, 32'h0000_FFFF}
  };

  string directed_text [N_DIRECTED] = '{
    "0000000000", "4294967295", "1234567890", "2147483648", "4294967295.",
    "01234567.89", "4294967295", "4000000000", "7295", "672", "42949", "4",
    "4.", "429.4", "", "", "9.", "9", "4", "?", "?", "?"
  };

  binary_to_decimal_ascii_formatter_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char_out (out_char_out),
    .out_last     (out_last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  // decimal digits of one word, windowed and dotted per the current format
  function automatic void queue_expected(input logic [IN_VALUE_W-1:0] v);
    logic [DIGIT_W-1:0] digs [N_DIGITS];
    longint unsigned    rest;
    int                 i, k, start, len, dot_at;
    text_char_t         tc;
    rest = v;
    for (i = 0; i < N_DIGITS; i++) begin
      digs[i] = DIGIT_W'(rest % 10);
      rest = rest / 10;
    end
    start = fmt_first;
    if (start >= N_DIGITS) start = N_DIGITS - 1;
    len = fmt_count;
    if (len > N_DIGITS - start) len = N_DIGITS - start;
    dot_at = 0;
    if (fmt_dot && fmt_decimals < len) dot_at = len - fmt_decimals;
    for (k = 1; k <= len; k++) begin
      tc.ch = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digs[start + len - k]};
      tc.last = (k == len) && (dot_at != len);
      expected_text.push_back(tc);
      if (k == dot_at) begin
        tc.ch = CHAR_DOT;
        tc.last = (k == len);
        expected_text.push_back(tc);
      end
    end
  endfunction

  function automatic void queue_literal(input string s);
    text_char_t tc;
    int         i;
    for (i = 0; i < s.len(); i++) begin
      tc.ch = s[i];
      tc.last = (i == s.len() - 1);
      expected_text.push_back(tc);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [IN_VALUE_W-1:0] random_value();
    longint unsigned p;
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 999);
      2: begin
        p = 1;
        repeat ($urandom_range(1, 9)) p = p * 10;
        return IN_VALUE_W'(p - $urandom_range(0, 1));
      end
      3: return $urandom_range(0, 1) ? '1 : '0;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    @(negedge clk);
  endtask

  // only while idle: drain, let any empty-window word finish, then write
  task automatic program_format(input logic [CFG_W-1:0] count, first, decimals, dot_data);
    in_valid = 1'b0;
    while (expected_text.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(REG_DIGIT_COUNT, count);
    write_reg(REG_FIRST_DIGIT, first);
    write_reg(REG_DECIMAL_DIGITS, decimals);
    write_reg(REG_DOT_ENABLE, dot_data);
    cfg_we = 1'b0;
    fmt_count = count;
    fmt_first = first;
    fmt_decimals = decimals;
    fmt_dot = dot_data[0];
    cfg_written = {count, first, decimals, dot_data};
  endtask

  // entered and left at a falling edge; valid stays up when no gap follows
  task automatic send_word(input logic [IN_VALUE_W-1:0] v, input string lit);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_value = v;
    do @(posedge clk); while (in_stall);
    if (lit == "?") queue_expected(v);
    else queue_literal(lit);
    @(negedge clk);
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (free_left > 0) begin
      free_left--;
      out_stall <= 1'b0;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: free_left = $urandom_range(0, 8);
        4:          free_left = $urandom_range(20, 60);
        5, 6, 7, 8: stall_left = $urandom_range(1, 3);
        default:    stall_left = $urandom_range(10, 30);
      endcase
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_text.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: char %h last %b", out_char_out, out_last);
      end else begin
        want = expected_text.pop_front();
        if (out_char_out !== want.ch || out_last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: char exp %h got %h, last exp %b got %b",
                     want.ch, out_char_out, want.last, out_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int                 r, p, n;
    logic [CFG_W-1:0]   c_count, c_first, c_decimals, c_dot;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    for (r = 0; r < N_DIRECTED; r++) begin
      if ({directed_rows[r].count, directed_rows[r].first, directed_rows[r].decimals,
           directed_rows[r].dot_data} != cfg_written)
        program_format(directed_rows[r].count, directed_rows[r].first,
                       directed_rows[r].decimals, directed_rows[r].dot_data);
      send_word(directed_rows[r].value, directed_text[r]);
    end

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: {c_count, c_first, c_decimals, c_dot} = {4'd10, 4'd0, 4'd0, 4'h1};
        1: {c_count, c_first, c_decimals, c_dot} = {4'd1, 4'd0, 4'd0, 4'h1};
        2: {c_count, c_first, c_decimals, c_dot} = {4'd15, 4'd15, 4'd15, 4'hF};
        5: {c_count, c_first, c_decimals, c_dot} = {4'd10, 4'd0, 4'd0, 4'hE};
        default: begin
          c_count = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 15))
                                                : CFG_W'($urandom_range(1, 10));
          c_first = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 15))
                                                : CFG_W'($urandom_range(0, 9));
          c_decimals = CFG_W'($urandom_range(0, 15));
          c_dot = CFG_W'($urandom_range(0, 15));
        end
      endcase
      program_format(c_count, c_first, c_decimals, c_dot);
      // long receiver hold while words keep coming: fills the block up
      if (p == 0) hold_req = 1'b1;
      for (n = 0; n < WORDS_PER_PHASE; n++) send_word(random_value(), "?");
    end

    in_valid = 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_text.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
design/bdf_pkg.sv
design/bdf_ctrl.sv
design/bdf_datapath.sv
design/binary_to_decimal_ascii_formatter_top.sv
dv/binary_to_decimal_ascii_formatter_top_tb.sv
